// ----- src/csa_pkg.sv -----
// shared constants and types for the client slot allocator
package csa_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ID_W       = 6;
    localparam int ID_EXT_W   = ID_W + 1;
    localparam int HANDLE_W   = 31;
    localparam int COUNT_W    = 7;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_RELEASE   = 2'd1,
        OP_LOOKUP    = 2'd2,
        OP_BROADCAST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_ID  = 2'd2
    } status_t;

endpackage

// ----- src/client_slot_allocator.sv -----
// top level of the client slot allocator: slot table, free stack and broadcast walk
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  opcode, slot_id, queue_handle
//  out      output     out_valid/out_ready  status, result_slot, result_handle,
//                                           slot_valid, active_count, last_of_run
//
//  allocate, release and lookup: accept with memory read, then execute
//  broadcast: accept, then scan each slot up to the last valid one, with a
//  handle ram read before each valid slot's result
//  one item at a time; in_ready is high only while idle
//  the output register is held while out_ready is low, which stalls execution
//  reset clears valid bits and counters at once; no clearing pass
module client_slot_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [csa_pkg::ID_W-1:0]      slot_id,
    input  logic [csa_pkg::HANDLE_W-1:0]  queue_handle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [csa_pkg::ID_W-1:0]      result_slot,
    output logic [csa_pkg::HANDLE_W-1:0]  result_handle,
    output logic                          slot_valid,
    output logic [csa_pkg::COUNT_W-1:0]   active_count,
    output logic                          last_of_run
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BC_SCAN,
        S_BC_EMIT
    } state_t;

    state_t                             state_reg, state_next;
    csa_pkg::op_t                       op_reg, op_next;
    logic [csa_pkg::ID_W-1:0]           id_reg, id_next;
    logic [csa_pkg::HANDLE_W-1:0]       handle_reg, handle_next;
    logic [csa_pkg::SLOT_COUNT-1:0]     valid_bits_reg, valid_bits_next;
    logic [csa_pkg::SLOT_COUNT-1:0]     mask_reg, mask_next;
    logic [csa_pkg::SLOT_W-1:0]         scan_reg, scan_next;
    logic [csa_pkg::CNT_W-1:0]          free_depth_reg, free_depth_next;
    logic [csa_pkg::CNT_W-1:0]          high_water_reg, high_water_next;
    logic [csa_pkg::CNT_W-1:0]          used_count_reg, used_count_next;

    logic                               out_valid_reg, out_valid_next;
    csa_pkg::status_t                   status_reg, status_next;
    logic [csa_pkg::ID_W-1:0]           result_slot_reg, result_slot_next;
    logic [csa_pkg::HANDLE_W-1:0]       result_handle_reg, result_handle_next;
    logic                               slot_valid_reg, slot_valid_next;
    logic                               last_reg, last_next;

    logic                               h_wr_en;
    logic [csa_pkg::SLOT_W-1:0]         h_wr_addr;
    logic                               h_rd_en;
    logic [csa_pkg::SLOT_W-1:0]         h_rd_addr;
    logic [csa_pkg::HANDLE_W-1:0]       h_rd_data;
    logic                               s_wr_en;
    logic                               s_rd_en;
    logic [csa_pkg::SLOT_W-1:0]         s_rd_addr;
    logic [csa_pkg::SLOT_W-1:0]         s_rd_data;

    logic [csa_pkg::SLOT_COUNT-1:0]     below_hw;
    logic [csa_pkg::SLOT_COUNT-1:0]     scan_onehot;
    logic                               out_free;
    logic                               in_range;
    logic [csa_pkg::SLOT_W-1:0]         id_idx;
    logic [csa_pkg::SLOT_W-1:0]         alloc_slot;

    csa_ram #(
        .WIDTH (csa_pkg::HANDLE_W),
        .DEPTH (csa_pkg::SLOT_COUNT)
    ) u_handle_ram (
        .clk     (clk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (handle_reg),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    csa_ram #(
        .WIDTH (csa_pkg::SLOT_W),
        .DEPTH (csa_pkg::SLOT_COUNT)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (s_wr_en),
        .wr_addr (free_depth_reg[csa_pkg::SLOT_W-1:0]),
        .wr_data (id_idx),
        .rd_en   (s_rd_en),
        .rd_addr (s_rd_addr),
        .rd_data (s_rd_data)
    );

    always_comb
    begin
        for (int j = 0; j < csa_pkg::SLOT_COUNT; j++)
        begin
            below_hw[j]    = csa_pkg::CNT_W'(j) < high_water_reg;
            scan_onehot[j] = csa_pkg::SLOT_W'(j) == scan_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign id_idx   = id_reg[csa_pkg::SLOT_W-1:0];
    assign in_range = csa_pkg::ID_EXT_W'(id_reg) < csa_pkg::ID_EXT_W'(csa_pkg::SLOT_COUNT);
    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        id_next            = id_reg;
        handle_next        = handle_reg;
        valid_bits_next    = valid_bits_reg;
        mask_next          = mask_reg;
        scan_next          = scan_reg;
        free_depth_next    = free_depth_reg;
        high_water_next    = high_water_reg;
        used_count_next    = used_count_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        status_next        = status_reg;
        result_slot_next   = result_slot_reg;
        result_handle_next = result_handle_reg;
        slot_valid_next    = slot_valid_reg;
        last_next          = last_reg;
        h_wr_en            = 1'b0;
        h_wr_addr          = id_idx;
        h_rd_en            = 1'b0;
        h_rd_addr          = slot_id[csa_pkg::SLOT_W-1:0];
        s_wr_en            = 1'b0;
        s_rd_en            = 1'b0;
        s_rd_addr          = csa_pkg::SLOT_W'(free_depth_reg - csa_pkg::CNT_W'(1));
        alloc_slot         = s_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = csa_pkg::op_t'(opcode);
                    id_next     = slot_id;
                    handle_next = queue_handle;
                    h_rd_en     = 1'b1;
                    s_rd_en     = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    last_next          = 1'b1;
                    result_handle_next = '0;
                    slot_valid_next    = 1'b0;
                    result_slot_next   = id_reg;
                    status_next        = csa_pkg::ST_OK;
                    state_next         = S_IDLE;
                    unique case (op_reg)
                        csa_pkg::OP_ALLOC:
                        begin
                            if (free_depth_reg != '0 ||
                                high_water_reg < csa_pkg::CNT_W'(csa_pkg::SLOT_COUNT))
                            begin
                                if (free_depth_reg != '0)
                                begin
                                    alloc_slot      = s_rd_data;
                                    free_depth_next = free_depth_reg - csa_pkg::CNT_W'(1);
                                end
                                else
                                begin
                                    alloc_slot      = high_water_reg[csa_pkg::SLOT_W-1:0];
                                    high_water_next = high_water_reg + csa_pkg::CNT_W'(1);
                                end
                                h_wr_en                     = 1'b1;
                                h_wr_addr                   = alloc_slot;
                                valid_bits_next[alloc_slot] = 1'b1;
                                used_count_next = used_count_reg +
                                    csa_pkg::CNT_W'(!valid_bits_reg[alloc_slot]);
                                result_slot_next   = csa_pkg::ID_W'(alloc_slot);
                                result_handle_next = handle_reg;
                                slot_valid_next    = 1'b1;
                            end
                            else
                            begin
                                status_next      = csa_pkg::ST_FULL;
                                result_slot_next = '0;
                            end
                        end
                        csa_pkg::OP_RELEASE:
                        begin
                            if (in_range && valid_bits_reg[id_idx] &&
                                free_depth_reg < csa_pkg::CNT_W'(csa_pkg::SLOT_COUNT))
                            begin
                                valid_bits_next[id_idx] = 1'b0;
                                used_count_next = used_count_reg - csa_pkg::CNT_W'(1);
                                free_depth_next = free_depth_reg + csa_pkg::CNT_W'(1);
                                s_wr_en         = 1'b1;
                            end
                            else
                            begin
                                status_next = csa_pkg::ST_BAD_ID;
                            end
                        end
                        csa_pkg::OP_LOOKUP:
                        begin
                            if (!in_range)
                            begin
                                status_next = csa_pkg::ST_BAD_ID;
                            end
                            else if (valid_bits_reg[id_idx])
                            begin
                                result_handle_next = h_rd_data;
                                slot_valid_next    = 1'b1;
                            end
                        end
                        csa_pkg::OP_BROADCAST:
                        begin
                            // empty table gives a single blank result
                            result_slot_next = '0;
                            if ((valid_bits_reg & below_hw) != '0)
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                mask_next      = valid_bits_reg & below_hw;
                                scan_next      = '0;
                                state_next     = S_BC_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BC_SCAN:
            begin
                if ((mask_reg & scan_onehot) != '0)
                begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = scan_reg;
                    state_next = S_BC_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + csa_pkg::SLOT_W'(1);
                end
            end
            S_BC_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = csa_pkg::ST_OK;
                    result_slot_next   = csa_pkg::ID_W'(scan_reg);
                    result_handle_next = h_rd_data;
                    slot_valid_next    = 1'b1;
                    mask_next          = mask_reg & ~scan_onehot;
                    last_next          = (mask_reg & ~scan_onehot) == '0;
                    scan_next          = scan_reg + csa_pkg::SLOT_W'(1);
                    state_next = ((mask_reg & ~scan_onehot) == '0) ? S_IDLE : S_BC_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= csa_pkg::OP_ALLOC;
            id_reg            <= '0;
            handle_reg        <= '0;
            valid_bits_reg    <= '0;
            mask_reg          <= '0;
            scan_reg          <= '0;
            free_depth_reg    <= '0;
            high_water_reg    <= '0;
            used_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= csa_pkg::ST_OK;
            result_slot_reg   <= '0;
            result_handle_reg <= '0;
            slot_valid_reg    <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            op_reg            <= op_next;
            id_reg            <= id_next;
            handle_reg        <= handle_next;
            valid_bits_reg    <= valid_bits_next;
            mask_reg          <= mask_next;
            scan_reg          <= scan_next;
            free_depth_reg    <= free_depth_next;
            high_water_reg    <= high_water_next;
            used_count_reg    <= used_count_next;
            out_valid_reg     <= out_valid_next;
            status_reg        <= status_next;
            result_slot_reg   <= result_slot_next;
            result_handle_reg <= result_handle_next;
            slot_valid_reg    <= slot_valid_next;
            last_reg          <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_slot   = result_slot_reg;
    assign result_handle = result_handle_reg;
    assign slot_valid    = slot_valid_reg;
    assign active_count  = csa_pkg::COUNT_W'(used_count_reg);
    assign last_of_run   = last_reg;

    // every slot below the mark is either in use or on the free stack
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (free_depth_reg + used_count_reg) == high_water_reg)
        else $error("free depth and used count do not add up to the high-water mark");

    a_used_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_bits_reg) == int'(used_count_reg))
        else $error("used count differs from the number of valid slots");

    a_valid_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_bits_reg & ~below_hw) == '0)
        else $error("valid slot at or above the high-water mark");

    a_walk_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BC_EMIT && out_free && (mask_reg & ~scan_onehot) == '0)
        |=> (state_reg == S_IDLE && out_valid_reg && last_reg))
        else $error("broadcast walk ended without a final item");

endmodule

// ----- src/csa_ram.sv -----
// generic single write port, single read port ram with registered read
module csa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
